FILE: hdl/rpn_pkg.sv
package rpn_pkg;

  typedef enum logic [3:0] {
    REQ_PUSH  = 4'd0,
    REQ_ADD   = 4'd1,
    REQ_SUB   = 4'd2,
    REQ_MUL   = 4'd3,
    REQ_DIV   = 4'd4,
    REQ_REM   = 4'd5,
    REQ_PEEK  = 4'd6,
    REQ_SWAP  = 4'd7,
    REQ_CLEAR = 4'd8,
    REQ_PRINT = 4'd9
  } req_e;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_ZDIV  = 3'd3;
  localparam logic [2:0] ST_SAT   = 3'd4;

  // classified token handed from front to back
  typedef struct packed {
    logic [3:0]  req;
    logic        known;
    logic signed [31:0] operand;
  } tok_t;

endpackage

FILE: hdl/rpn_front.sv
module rpn_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [3:0]         req_type_i,
  input  logic signed [31:0] operand_value_i,
  output logic               tok_valid_o,
  input  logic               tok_pop_i,
  output rpn_pkg::tok_t      tok_o
);
  import rpn_pkg::*;

  // two-entry queue
  tok_t        mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push;

  assign stall_o     = (cnt_q == 2'd2);
  assign push        = valid_i && !stall_o;
  assign tok_valid_o = (cnt_q != 2'd0);
  assign tok_o       = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q].req     <= req_type_i;
      mem_q[wp_q].known   <= (req_type_i <= 4'd9);
      mem_q[wp_q].operand <= operand_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (tok_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, tok_pop_i};
    end
  end
endmodule

FILE: hdl/rpn_divider.sv
module rpn_divider #(
  parameter int unsigned Width = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] num_i,
  input  logic [Width-1:0] den_i,
  output logic             done_o,
  output logic [Width-1:0] quo_o,
  output logic [Width-1:0] rem_o
);
  // unsigned restoring divider, one quotient bit per cycle
  localparam int unsigned CntW = $clog2(Width + 1);

  logic [Width-1:0] quo_q, quo_d, rem_q, rem_d, den_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic [Width:0]   trial;

  always_comb begin
    trial = {rem_q, quo_q[Width-1]} - {1'b0, den_q};
    quo_d = {quo_q[Width-2:0], 1'b0};
    rem_d = {rem_q[Width-2:0], quo_q[Width-1]};
    if (!trial[Width]) begin
      rem_d    = trial[Width-1:0];
      quo_d[0] = 1'b1;
    end
  end

  assign quo_o = quo_q;
  assign rem_o = rem_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Width);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: hdl/rpn_back.sv
module rpn_back #(
  parameter int unsigned StackDepth = 128,
  parameter int unsigned FracBits   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tok_valid_i,
  output logic               tok_pop_o,
  input  rpn_pkg::tok_t      tok_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [31:0] top_value_o,
  output logic signed [31:0] second_value_o,
  output logic [7:0]         stack_depth_o,
  output logic [2:0]         status_o
);
  import rpn_pkg::*;

  localparam int unsigned AW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned DW = $clog2(StackDepth + 1);
  localparam logic signed [63:0] MaxV = 64'sd2147483647;
  localparam logic signed [63:0] MinV = -64'sd2147483648;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RD0   = 11'b00000000010,
    S_RD1   = 11'b00000000100,
    S_MUL   = 11'b00000001000,
    S_DIV   = 11'b00000010000,
    S_DIVW  = 11'b00000100000,
    S_FIN   = 11'b00001000000,
    S_SWAPW = 11'b00010000000,
    S_REF0  = 11'b00100000000,
    S_REF1  = 11'b01000000000,
    S_REF2  = 11'b10000000000
  } state_e;

  state_e state_q;
  logic signed [31:0] mem_q [StackDepth];
  logic signed [31:0] rd_q;
  logic               rd_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               wr_en;
  logic signed [31:0] wr_data;

  logic [DW-1:0]      depth_q;
  tok_t               tok_q;
  logic signed [31:0] a_q, b_q, popped_q;
  logic               empty_q, ovf_q;
  logic [2:0]         stat_q;
  logic signed [63:0] res_q, prod_q;

  logic               ov_q;
  logic signed [31:0] top_q, sec_q;
  logic [7:0]         dep_q;
  logic [2:0]         st_q;

  // divider
  logic        dv_start, dv_done;
  logic [63:0] dv_num, dv_den, dv_quo, dv_rem;
  logic        neg_q, anegs_q;

  rpn_divider #(.Width(64)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_quo), .rem_o(dv_rem)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  assign valid_o        = ov_q;
  assign top_value_o    = top_q;
  assign second_value_o = sec_q;
  assign stack_depth_o  = dep_q;
  assign status_o       = st_q;

  logic [DW-1:0] d1, d2;
  assign d1 = depth_q - DW'(1);
  assign d2 = depth_q - DW'(2);

  logic signed [63:0] sat_in;
  logic signed [31:0] sat_out;
  logic               sat_flag;
  always_comb begin
    sat_in   = res_q;
    sat_flag = 1'b0;
    sat_out  = sat_in[31:0];
    if (sat_in > MaxV) begin sat_out = 32'sh7fffffff; sat_flag = 1'b1; end
    if (sat_in < MinV) begin sat_out = 32'sh80000000; sat_flag = 1'b1; end
  end

  logic signed [63:0] mul_sh;
  always_comb begin
    mul_sh = prod_q >>> FracBits; // arithmetic shift floors
  end

  logic [63:0] a_abs, b_abs;
  always_comb begin
    a_abs  = a_q[31] ? 64'(-{{32{a_q[31]}}, a_q}) : 64'({32'd0, a_q});
    b_abs  = b_q[31] ? 64'(-{{32{b_q[31]}}, b_q}) : 64'({32'd0, b_q});
    dv_num = (tok_q.req == REQ_DIV) ? (a_abs << FracBits) : a_abs;
    dv_den = b_abs;
  end

  // combinational control
  logic out_free;
  assign out_free = !ov_q || !stall_i;

  always_comb begin
    tok_pop_o = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = d1[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = depth_q[AW-1:0];
    wr_data   = tok_i.operand;
    dv_start  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (tok_valid_i && out_free) begin
          tok_pop_o = 1'b1;
          if (tok_i.req == REQ_PUSH && depth_q < DW'(StackDepth)) wr_en = 1'b1;
          rd_en = 1'b1;
        end
      end
      S_RD0: begin
        rd_en   = 1'b1;
        rd_addr = d2[AW-1:0];
      end
      S_RD1: begin
        rd_en   = 1'b1;
        rd_addr = d1[AW-1:0];
        // swap: old second goes to the top slot
        if (tok_q.req == REQ_SWAP) begin
          wr_en   = 1'b1;
          wr_addr = d1[AW-1:0];
          wr_data = rd_q;
        end
      end
      S_DIV: dv_start = 1'b1;
      S_FIN: begin
        wr_en   = 1'b1;
        wr_addr = depth_q[AW-1:0];
        wr_data = sat_out;
      end
      S_SWAPW: begin
        wr_en   = 1'b1;
        wr_addr = d2[AW-1:0];
        wr_data = b_q;
      end
      S_REF0: begin
        rd_en   = 1'b1;
        rd_addr = d1[AW-1:0];
      end
      S_REF1: begin
        rd_en   = 1'b1;
        rd_addr = d2[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && tok_valid_i && out_free) tok_q <= tok_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      depth_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (ov_q && !stall_i) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (tok_valid_i && out_free) begin
            stat_q  <= ST_OK;
            empty_q <= 1'b0;
            ovf_q   <= 1'b0;
            state_q <= S_REF0;
            if (!tok_i.known) begin
              state_q <= S_REF0;
            end else begin
              case (tok_i.req)
                REQ_PUSH: begin
                  if (depth_q < DW'(StackDepth)) depth_q <= depth_q + DW'(1);
                  else stat_q <= ST_FULL;
                end
                REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV, REQ_REM: state_q <= S_RD0;
                REQ_PEEK: if (depth_q < DW'(2)) stat_q <= ST_EMPTY;
                REQ_SWAP: begin
                  if (depth_q < DW'(2)) stat_q <= ST_EMPTY;
                  else state_q <= S_RD0;
                end
                REQ_CLEAR: depth_q <= '0;
                REQ_PRINT: state_q <= S_RD0;
                default: ;
              endcase
            end
          end
        end
        S_RD0: begin
          // rd_q = top
          if (tok_q.req == REQ_PRINT) begin
            if (depth_q == '0) begin
              popped_q <= '0;
              stat_q   <= ST_EMPTY;
            end else begin
              popped_q <= rd_q;
              depth_q  <= d1;
            end
            state_q <= S_REF0;
          end else if (tok_q.req == REQ_SWAP) begin
            b_q     <= rd_q;
            state_q <= S_RD1;
          end else begin
            b_q     <= (depth_q == '0) ? 32'sd0 : rd_q;
            state_q <= S_RD1;
          end
        end
        S_RD1: begin
          // rd_q = second (read at d2)
          if (tok_q.req == REQ_SWAP) begin
            a_q     <= rd_q;
            state_q <= S_SWAPW;
          end else if ((tok_q.req == REQ_DIV || tok_q.req == REQ_REM) && b_q == 0) begin
            if (depth_q == '0) stat_q <= ST_EMPTY;
            else begin
              stat_q  <= ST_ZDIV;
              depth_q <= d1;
            end
            state_q <= S_REF0;
          end else begin
            empty_q <= (depth_q < DW'(2));
            a_q     <= (depth_q < DW'(2)) ? 32'sd0 : rd_q;
            depth_q <= (depth_q < DW'(2)) ? '0 : d2;
            case (tok_q.req)
              REQ_ADD: begin
                res_q   <= 64'(((depth_q < DW'(2)) ? 32'sd0 : rd_q)) + 64'(b_q);
                state_q <= S_FIN;
              end
              REQ_SUB: begin
                res_q   <= 64'(((depth_q < DW'(2)) ? 32'sd0 : rd_q)) - 64'(b_q);
                state_q <= S_FIN;
              end
              REQ_MUL: state_q <= S_MUL;
              default: state_q <= S_DIV;
            endcase
          end
        end
        S_MUL: begin
          prod_q  <= 64'(a_q) * 64'(b_q);
          state_q <= S_DIVW; // reuse S_DIVW to apply the shift
          ovf_q   <= 1'b1;
        end
        S_DIV: begin
          neg_q   <= a_q[31] ^ b_q[31];
          anegs_q <= a_q[31];
          state_q <= S_DIVW;
        end
        S_DIVW: begin
          if (ovf_q) begin
            res_q   <= mul_sh;
            state_q <= S_FIN;
          end else if (dv_done) begin
            if (tok_q.req == REQ_DIV)
              res_q <= neg_q ? 64'(-dv_quo) : dv_quo;
            else
              res_q <= anegs_q ? 64'(-dv_rem) : dv_rem;
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          depth_q <= depth_q + DW'(1);
          if (empty_q) stat_q <= ST_EMPTY;
          else if (sat_flag) stat_q <= ST_SAT;
          state_q <= S_REF0;
        end
        S_SWAPW: state_q <= S_REF0; // top slot written in S_RD1, second here
        S_REF0: state_q <= S_REF1;
        S_REF1: begin
          // rd_q = top, second read in flight
          a_q     <= rd_q;
          state_q <= S_REF2;
        end
        S_REF2: begin
          ov_q  <= 1'b1;
          dep_q <= 8'(depth_q);
          st_q  <= stat_q;
          if (tok_q.req == REQ_PRINT) begin
            top_q <= popped_q;
            sec_q <= (depth_q >= DW'(1)) ? a_q : 32'sd0;
          end else begin
            top_q <= (depth_q >= DW'(1)) ? a_q : 32'sd0;
            sec_q <= (depth_q >= DW'(2)) ? rd_q : 32'sd0;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hdl/rpn_stack_calculator.sv
// RPN stack calculator, signed fixed-point.
// Input channel: valid_i/stall_o with req_type_i and operand_value_i, one
// token per beat. Output channel: valid_o/stall_i with top_value_o,
// second_value_o, stack_depth_o and status_o, one result beat per token.
// A two-entry token queue decouples the front from the execute back end.
// Every token ends in the refresh states S_REF0, S_REF1 and S_REF2, which
// read the top two entries and register the result beat. Add, sub, mul,
// div, rem and swap first read the operands in S_RD0 and S_RD1; div/rem
// then waits on the 64-bit one-bit-per-cycle divider. Tokens are executed
// one at a time; the next one starts in the same cycle as the previous
// result is accepted. Reset clears the depth, the queue and the output
// valid; stack contents are undefined until pushed. A stalled result
// holds and blocks the back end, the queue then fills and stall_o rises.
module rpn_stack_calculator #(
  parameter int unsigned STACK_DEPTH = 128,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [3:0]         req_type_i,
  input  logic signed [31:0] operand_value_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [31:0] top_value_o,
  output logic signed [31:0] second_value_o,
  output logic [7:0]         stack_depth_o,
  output logic [2:0]         status_o
);
  import rpn_pkg::*;

  tok_t tok;
  logic tok_valid, tok_pop;

  rpn_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .req_type_i, .operand_value_i,
    .tok_valid_o(tok_valid), .tok_pop_i(tok_pop), .tok_o(tok)
  );

  rpn_back #(.StackDepth(STACK_DEPTH), .FracBits(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .tok_valid_i(tok_valid), .tok_pop_o(tok_pop), .tok_i(tok),
    .valid_o, .stall_i, .top_value_o, .second_value_o, .stack_depth_o, .status_o
  );
endmodule
